/* sv/lgu_pkg.sv */
// Shared types and constants for the loss gradient unit.
`default_nettype none
package lgu_pkg;

  localparam int unsigned MAX_LENGTH = 4096;

  localparam int unsigned EST_W      = 16;  // Q4.12 operands
  localparam int unsigned GRAD_W     = 24;  // Q12.12 result
  localparam int unsigned QUO_W      = 24;  // quotient bits built by the cell chain
  localparam int unsigned DMAG_W     = 16;  // |difference| width
  localparam int unsigned BCE_SHIFT  = 24;  // 2^24 scale of the BCE numerator
  localparam int unsigned MAG_W      = DMAG_W + BCE_SHIFT;
  localparam int unsigned Y_W        = 12;  // clamped BCE estimate
  localparam int unsigned PROD_W     = 23;  // y*(1-y), peak 2^22
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // three front stages, the cell chain, the output register
  localparam int unsigned LATENCY    = 3 + QUO_W + 1;

  localparam logic [Y_W-1:0]    Y_MIN     = 12'd1;
  localparam logic [Y_W-1:0]    Y_MAX     = 12'd4095;
  localparam logic [Y_W:0]      ONE_Q12   = 13'd4096;
  localparam logic [GRAD_W-1:0] GRAD_POS  = 24'h7FFFFF;
  localparam logic [GRAD_W-1:0] GRAD_NEG  = 24'h800000;

  typedef enum logic [1:0] {
    MODE_MSE = 2'd0,
    MODE_BCE = 2'd1,
    MODE_CCE = 2'd2
  } loss_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOSS_MODE     = 2'd0,
    REG_VECTOR_LENGTH = 2'd1
  } cfg_reg_e;

  // control that travels alongside each beat
  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } lgu_ctl_t;

endpackage
`default_nettype wire

/* sv/lgu_front.sv */
// Front stages: clamp, difference, denominator products, divider setup.
`default_nettype none
module lgu_front import lgu_pkg::*; #(
  parameter int unsigned MaxLength = MAX_LENGTH,
  localparam int unsigned LenW = $clog2(MaxLength + 1),
  localparam int unsigned DenW = PROD_W + LenW,
  localparam int unsigned DivW = DenW + 1,
  localparam int unsigned NumW = ((MAG_W + 1 > DenW) ? MAG_W + 1 : DenW) + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    take_i,
  input  wire logic signed [EST_W-1:0] estimate_i,
  input  wire logic signed [EST_W-1:0] target_i,
  input  wire loss_mode_e              mode_i,
  input  wire logic [LenW-1:0]         len_i,
  output lgu_ctl_t                     ctl_o,
  output logic [DivW-1:0]              rem_o,
  output logic [DivW-1:0]              den_o,
  output logic [QUO_W-1:0]             low_o
);

  // stage 0
  logic [Y_W-1:0]           y;
  logic signed [EST_W:0]    opa;
  logic signed [EST_W:0]    diff;
  logic signed [EST_W:0]    diff_neg;
  logic [PROD_W+1:0]        prod_full;
  logic                     v0_q;
  logic                     neg0_q;
  logic [DMAG_W-1:0]        dmag0_q;
  loss_mode_e               mode0_q;
  logic [LenW-1:0]          len0_q;
  logic [PROD_W-1:0]        prod0_q;

  // stage 1
  logic [DenW-1:0]          mulp;
  logic [DenW-1:0]          den1_d;
  logic [MAG_W-1:0]         mag1_d;
  logic                     v1_q;
  logic                     neg1_q;
  logic [DenW-1:0]          den1_q;
  logic [MAG_W-1:0]         mag1_q;

  // stage 2
  logic [NumW-1:0]          np;
  logic [DivW-1:0]          dp;
  logic [DivW-1:0]          hi;
  lgu_ctl_t                 ctl_q;
  logic [DivW-1:0]          rem_q;
  logic [DivW-1:0]          den_q;
  logic [QUO_W-1:0]         low_q;

  always_comb begin
    if (estimate_i < $signed({{(EST_W-Y_W){1'b0}}, Y_MIN})) begin
      y = Y_MIN;
    end else if (estimate_i > $signed({{(EST_W-Y_W){1'b0}}, Y_MAX})) begin
      y = Y_MAX;
    end else begin
      y = estimate_i[Y_W-1:0];
    end
    if (mode_i == MODE_BCE) begin
      opa = $signed({{(EST_W+1-Y_W){1'b0}}, y});
    end else begin
      opa = {estimate_i[EST_W-1], estimate_i};
    end
    diff      = opa - {target_i[EST_W-1], target_i};
    diff_neg  = -diff;
    prod_full = y * (ONE_Q12 - {1'b0, y});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q  <= diff[EST_W];
    dmag0_q <= diff[EST_W] ? diff_neg[DMAG_W-1:0] : diff[DMAG_W-1:0];
    mode0_q <= mode_i;
    len0_q  <= len_i;
    prod0_q <= prod_full[PROD_W-1:0];
  end

  assign mulp = prod0_q * len0_q;

  always_comb begin
    den1_d = (mode0_q == MODE_BCE) ? mulp : DenW'(len0_q);
    unique case (mode0_q)
      MODE_MSE: mag1_d = MAG_W'({dmag0_q, 1'b0});
      MODE_CCE: mag1_d = MAG_W'(dmag0_q);
      MODE_BCE: mag1_d = {dmag0_q, {BCE_SHIFT{1'b0}}};
      default:  mag1_d = '0;  // unused mode: zero numerator gives zero
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= neg0_q;
    den1_q <= den1_d;
    mag1_q <= mag1_d;
  end

  // round half away: floor((2|num| + den) / (2 den))
  always_comb begin
    np = NumW'({mag1_q, 1'b0}) + NumW'(den1_q);
    dp = {den1_q, 1'b0};
    hi = DivW'(np >> QUO_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= v1_q;
      ctl_q.neg   <= neg1_q;
      ctl_q.ovf   <= (hi >= dp);  // quotient would need more than QUO_W bits
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= hi;
    den_q <= dp;
    low_q <= np[QUO_W-1:0];
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign low_o = low_q;

endmodule
`default_nettype wire

/* sv/lgu_div_cell.sv */
// One restoring-division cell: brings in a numerator bit, yields a quotient bit.
`default_nettype none
module lgu_div_cell import lgu_pkg::*; #(
  parameter int unsigned DivW = 36
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lgu_ctl_t         ctl_i,
  input  wire logic [DivW-1:0]  rem_i,
  input  wire logic [DivW-1:0]  den_i,
  input  wire logic [QUO_W-1:0] low_i,
  input  wire logic [QUO_W-1:0] quo_i,
  output lgu_ctl_t              ctl_o,
  output logic [DivW-1:0]       rem_o,
  output logic [DivW-1:0]       den_o,
  output logic [QUO_W-1:0]      low_o,
  output logic [QUO_W-1:0]      quo_o
);

  logic [DivW:0]    trial;
  logic [DivW:0]    sub;
  logic             ge;
  lgu_ctl_t         ctl_q;
  logic [DivW-1:0]  rem_q;
  logic [DivW-1:0]  den_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;

  always_comb begin
    trial = {rem_i, low_i[QUO_W-1]};
    sub   = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= ge ? sub[DivW-1:0] : trial[DivW-1:0];
    den_q <= den_i;
    low_q <= {low_i[QUO_W-2:0], 1'b0};
    quo_q <= {quo_i[QUO_W-2:0], ge};
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign low_o = low_q;
  assign quo_o = quo_q;

endmodule
`default_nettype wire

/* sv/loss_gradient_unit.sv */
// Top level: configuration registers, front stages, division cell chain, output register.
// Each accepted start passes the front stages, cell chain and output register in order.
// Throughput: one item per cycle, every cycle; busy_o stays low.
// The cell chain has 24 cells and builds one quotient bit per cell.
// Reset: loss_mode returns to MSE, vector_length to 1, all in-flight beats drop.
// Results cannot be stalled: each one shows for exactly one cycle.
`default_nettype none
module loss_gradient_unit import lgu_pkg::*; #(
  parameter int unsigned MaxLength = MAX_LENGTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // item channel
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [EST_W-1:0]  estimate_i,
  input  wire logic signed [EST_W-1:0]  target_i,
  // result channel
  output logic                          result_valid_o,
  output logic signed [GRAD_W-1:0]      gradient_o,
  output logic                          saturated_o,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned LenW = $clog2(MaxLength + 1);
  localparam int unsigned DenW = PROD_W + LenW;
  localparam int unsigned DivW = DenW + 1;

  // ---------------------------------------------------------------
  // Configuration. The length is stored already clamped to
  // [1, MaxLength] so the datapath never sees zero or an oversize n.
  // ---------------------------------------------------------------
  loss_mode_e        mode_q;
  logic [LenW-1:0]   len_q;
  logic [LenW-1:0]   len_d;

  always_comb begin
    if (cfg_data_i == '0) begin
      len_d = LenW'(1);
    end else if (32'(cfg_data_i) > 32'(MaxLength)) begin
      len_d = LenW'(MaxLength);
    end else begin
      len_d = LenW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MSE;
      len_q  <= LenW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LOSS_MODE:     mode_q <= loss_mode_e'(cfg_data_i[1:0]);
        REG_VECTOR_LENGTH: len_q  <= len_d;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // fully pipelined: always ready on both sides
  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // ---------------------------------------------------------------
  // Front: clamp for BCE, |difference|, y(1-y)n for BCE or n, then the rounded
  // numerator 2|num|+den and divisor 2den with an overflow check.
  // ---------------------------------------------------------------
  lgu_ctl_t           ctl_c [QUO_W+1];
  logic [DivW-1:0]    rem_c [QUO_W+1];
  logic [DivW-1:0]    den_c [QUO_W+1];
  logic [QUO_W-1:0]   low_c [QUO_W+1];
  logic [QUO_W-1:0]   quo_c [QUO_W+1];

  lgu_front #(
    .MaxLength (MaxLength)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start_i && !busy_o),
    .estimate_i (estimate_i),
    .target_i   (target_i),
    .mode_i     (mode_q),
    .len_i      (len_q),
    .ctl_o      (ctl_c[0]),
    .rem_o      (rem_c[0]),
    .den_o      (den_c[0]),
    .low_o      (low_c[0])
  );

  assign quo_c[0] = '0;

  // ---------------------------------------------------------------
  // Cell chain: each cell shifts in one numerator bit and emits one
  // quotient bit, passing the beat to its neighbor every cycle.
  // ---------------------------------------------------------------
  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_cell
    lgu_div_cell #(
      .DivW (DivW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[gi]),
      .rem_i  (rem_c[gi]),
      .den_i  (den_c[gi]),
      .low_i  (low_c[gi]),
      .quo_i  (quo_c[gi]),
      .ctl_o  (ctl_c[gi+1]),
      .rem_o  (rem_c[gi+1]),
      .den_o  (den_c[gi+1]),
      .low_o  (low_c[gi+1]),
      .quo_o  (quo_c[gi+1])
    );
  end

  // ---------------------------------------------------------------
  // Output: apply sign, saturate. A negative magnitude of exactly
  // 2^23 still fits; anything past the bound clamps and flags.
  // ---------------------------------------------------------------
  lgu_ctl_t           fin;
  logic [QUO_W-1:0]   quo;
  logic [GRAD_W-1:0]  grad_d;
  logic               sat_d;
  logic               valid_q;
  logic [GRAD_W-1:0]  grad_q;
  logic               sat_q;

  assign fin = ctl_c[QUO_W];
  assign quo = quo_c[QUO_W];

  always_comb begin
    if (fin.neg) begin
      if (fin.ovf || quo > GRAD_NEG) begin
        grad_d = GRAD_NEG;
        sat_d  = 1'b1;
      end else begin
        grad_d = -quo;
        sat_d  = 1'b0;
      end
    end else begin
      if (fin.ovf || quo > GRAD_POS) begin
        grad_d = GRAD_POS;
        sat_d  = 1'b1;
      end else begin
        grad_d = quo;
        sat_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    grad_q <= grad_d;
    sat_q  <= sat_d;
  end

  assign result_valid_o = valid_q;
  assign gradient_o     = $signed(grad_q);
  assign saturated_o    = sat_q;

endmodule
`default_nettype wire

/* sv/lgu_checker.sv */
// Port-level checks for the loss gradient unit, bound to the top level.
`default_nettype none
module lgu_checker import lgu_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start_i,
  input wire logic                     busy_o,
  input wire logic signed [EST_W-1:0]  estimate_i,
  input wire logic signed [EST_W-1:0]  target_i,
  input wire logic                     result_valid_o,
  input wire logic signed [GRAD_W-1:0] gradient_o,
  input wire logic                     saturated_o,
  input wire logic                     cfg_valid_i,
  input wire logic                     cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  logic               take;
  logic               zero_exp;
  logic [1:0]         mode_q;
  logic [LATENCY-1:0] acc_q;
  logic [LATENCY-1:0] zero_q;

  assign take     = start_i && !busy_o;
  // equal operands in a non-BCE mode must give an exact zero
  assign zero_exp = take && (estimate_i == target_i) && (mode_q != MODE_BCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MSE;
      acc_q  <= '0;
      zero_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_LOSS_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      acc_q  <= {acc_q[LATENCY-2:0], take};
      zero_q <= {zero_q[LATENCY-2:0], zero_exp};
    end
  end

  a_one_result_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == acc_q[LATENCY-1])
    else $error("result strobe does not match accepted beat");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && saturated_o |-> gradient_o == GRAD_POS || gradient_o == GRAD_NEG)
    else $error("saturated result not at a range bound");

  a_zero_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_q[LATENCY-1] |-> gradient_o == '0 && !saturated_o)
    else $error("equal operands gave nonzero gradient");

endmodule

bind loss_gradient_unit lgu_checker u_lgu_checker (.*);
`default_nettype wire

/* test/loss_gradient_unit_tb.sv */
// Self-checking testbench for loss_gradient_unit: directed corners, then random beats per mode.
module loss_gradient_unit_tb;
  import lgu_pkg::*;

  // Loss mode 3 has no enum member; the block must answer it with a zero gradient.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned BLOCKS_PER_PHASE = 6;
  localparam int unsigned BEATS_PER_BLOCK = 78;
  localparam int unsigned REPORT_LIMIT = 10;

  // One predicted result, with the operands kept for the mismatch report.
  typedef struct packed {
    logic [EST_W-1:0]         est;
    logic [EST_W-1:0]         tgt;
    logic signed [GRAD_W-1:0] grad;
    logic                     sat;
  } grad_beat_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic [EST_W-1:0]      estimate_i  = '0;
  logic [EST_W-1:0]      target_i    = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                     busy_o;
  logic                     result_valid_o;
  logic signed [GRAD_W-1:0] gradient_o;
  logic                     saturated_o;
  logic                     cfg_ready_o;

  // Predicted gradients in acceptance order; the block never reorders.
  grad_beat_t pending_grads[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  // Register copy kept by the monitor, updated on each accepted config beat.
  logic [1:0]            mode_q = MODE_MSE;
  logic [CFG_DATA_W-1:0] length_q = 13'd1;

  loss_gradient_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .estimate_i     (estimate_i),
    .target_i       (target_i),
    .result_valid_o (result_valid_o),
    .gradient_o     (gradient_o),
    .saturated_o    (saturated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Runaway guard: no correct run comes anywhere near this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // num/den rounded to nearest, ties away from zero; den is always positive.
  function automatic longint round_half_away(input longint num, input longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + den) / (2 * den);
    return (num < 0) ? -quo : quo;
  endfunction

  // Gradient for one estimate/target pair under the given mode and length.
  function automatic grad_beat_t predict_gradient(input logic [EST_W-1:0] est,
                                                  input logic [EST_W-1:0] tgt,
                                                  input logic [1:0] mode,
                                                  input logic [CFG_DATA_W-1:0] len);
    longint e;
    longint t;
    longint n;
    longint y;
    longint one;
    longint g;
    grad_beat_t res;
    e   = longint'($signed(est));
    t   = longint'($signed(tgt));
    one = longint'(ONE_Q12);
    // length 0 acts as 1, anything past the maximum as the maximum
    n = longint'(len);
    if (n == 0) n = 1;
    if (n > longint'(MAX_LENGTH)) n = longint'(MAX_LENGTH);
    case (mode)
      MODE_MSE: g = round_half_away(2 * (e - t), n);
      MODE_CCE: g = round_half_away(e - t, n);
      MODE_BCE: begin
        // clamp the estimate to [eps, 1-eps] before the divide
        y = e;
        if (y < longint'(Y_MIN)) y = longint'(Y_MIN);
        if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
        g = round_half_away((y - t) * one * one, y * (one - y) * n);
      end
      default: g = 0;
    endcase
    res.est = est;
    res.tgt = tgt;
    res.sat = 1'b0;
    if (g > longint'($signed(GRAD_POS))) begin
      g = longint'($signed(GRAD_POS));
      res.sat = 1'b1;
    end else if (g < longint'($signed(GRAD_NEG))) begin
      g = longint'($signed(GRAD_NEG));
      res.sat = 1'b1;
    end
    res.grad = GRAD_W'(g);
    return res;
  endfunction

  // Monitor: results are checked, accepted beats predicted, config beats tracked.
  // Everything samples pre-edge values, so ordering within the step is irrelevant.
  always @(posedge clk_i) begin
    grad_beat_t want;
    if (!rst_ni) begin
      mode_q   = MODE_MSE;
      length_q = 13'd1;
    end else begin
      if (result_valid_o) begin
        if (pending_grads.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: result %0d/%b with no beat pending", gradient_o, saturated_o);
        end else begin
          want = pending_grads.pop_front();
          if (gradient_o !== want.grad || saturated_o !== want.sat) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("ERROR: e=%0d t=%0d: gradient %0d sat %b, expected %0d sat %b",
                       $signed(want.est), $signed(want.tgt), gradient_o, saturated_o,
                       want.grad, want.sat);
          end
        end
      end
      if (start_i && !busy_o)
        pending_grads.push_back(predict_gradient(estimate_i, target_i, mode_q, length_q));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LOSS_MODE:     mode_q = cfg_data_i[1:0];
          REG_VECTOR_LENGTH: length_q = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Offer one pair; idle cycles in front carry junk operands the block must ignore.
  // start_i is left high so back-to-back beats need no extra assignment.
  task automatic send_pair(input logic [EST_W-1:0] est, input logic [EST_W-1:0] tgt);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i    <= 1'b0;
      estimate_i <= EST_W'($urandom);
      target_i   <= EST_W'($urandom);
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    estimate_i <= est;
    target_i   <= tgt;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop sending and wait for every pending gradient. The first edge lets the
  // monitor record the last accepted beat before the queue is looked at.
  task automatic drain;
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_grads.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Both registers, only with the pipe empty.
  task automatic configure(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] len);
    drain();
    write_reg(REG_LOSS_MODE, CFG_DATA_W'(mode));
    write_reg(REG_VECTOR_LENGTH, len);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values: MSE with n = 1, no config written yet.
  task automatic test_reset_values;
    sender_idle_pct = 0;
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h0001, 16'h0000);
  endtask

  // CCE with n = 2: +-1/2 must round away from zero.
  task automatic test_cce_rounding;
    configure(MODE_CCE, 13'd2);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
  endtask

  // BCE: clamp at both ends, far out-of-range targets saturating both ways.
  task automatic test_bce_clamp_and_saturation;
    configure(MODE_BCE, 13'd1);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h1000, 16'h1000);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h0001, 16'h8000);
    send_pair(16'h0FFF, 16'h7FFF);
    send_pair(16'h0800, 16'h0000);
  endtask

  // Zero length acts as 1; lengths past the maximum act as the maximum.
  task automatic test_length_corners;
    configure(MODE_MSE, 13'd0);
    send_pair(16'h0064, 16'h0000);
    configure(MODE_MSE, 13'h1FFF);
    send_pair(16'h7FFF, 16'h8000);
    configure(MODE_MSE, 13'd4097);
    send_pair(16'h8000, 16'h7FFF);
    configure(MODE_CCE, 13'd4096);
    send_pair(16'h7FFF, 16'h8000);
  endtask

  task automatic test_unused_mode;
    configure(MODE_UNUSED, 13'd5);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h007B, 16'hFFFB);
  endtask

  // Random blocks, each under a fresh configuration. BCE beats are mostly
  // probabilities in [0,1] with hard or soft targets; the rest is raw noise.
  task automatic test_random_phase(input int unsigned idle_pct);
    logic [1:0]            mode;
    logic [CFG_DATA_W-1:0] len;
    logic [EST_W-1:0]      est;
    logic [EST_W-1:0]      tgt;
    sender_idle_pct = idle_pct;
    for (int unsigned blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
      case (blk % 3)
        0: mode = MODE_MSE;
        1: mode = MODE_BCE;
        default: mode = MODE_CCE;
      endcase
      if ($urandom_range(9) == 0) mode = MODE_UNUSED;
      case ($urandom_range(7))
        0: len = 13'd1;
        1: len = 13'd0;
        2: len = 13'd4096;
        3: len = CFG_DATA_W'($urandom_range(8191, 4097));
        4, 5: len = CFG_DATA_W'($urandom_range(16, 1));
        default: len = CFG_DATA_W'($urandom_range(4096, 1));
      endcase
      configure(mode, len);
      for (int unsigned k = 0; k < BEATS_PER_BLOCK; k++) begin
        if (mode == MODE_BCE && $urandom_range(3) != 0) begin
          est = EST_W'($urandom_range(4096));
          case ($urandom_range(3))
            0: tgt = 16'h0000;
            1: tgt = 16'h1000;
            default: tgt = EST_W'($urandom_range(4096));
          endcase
        end else if (mode != MODE_BCE && $urandom_range(1) == 0) begin
          // nearby operands exercise the small-quotient rounding
          est = EST_W'(int'($urandom_range(8192)) - 4096);
          tgt = est + EST_W'(int'($urandom_range(64)) - 32);
        end else begin
          est = EST_W'($urandom);
          tgt = EST_W'($urandom);
        end
        send_pair(est, tgt);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_cce_rounding();
    test_bce_clamp_and_saturation();
    test_length_corners();
    test_unused_mode();
    test_random_phase(23);
    test_random_phase(67);
    test_random_phase(0);

    // settle, then stay quiet past the pipeline latency to catch stray strobes
    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_grads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
